[rtl/qat_pkg.sv]
`default_nettype none

package qat_pkg;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BARE  = 3'd1,
        PH_QUOTE = 3'd2,
        PH_BSL   = 3'd3,
        PH_OCT1  = 3'd4,
        PH_OCT2  = 3'd5,
        PH_HEX1  = 3'd6,
        PH_HEX2  = 3'd7
    } phase_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       arg_end;
    } qat_result_t;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_CR     = 8'h0d;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5a;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7a;
    localparam logic [7:0] CH_N      = 8'h6e;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_X      = 8'h78;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

endpackage

`default_nettype wire

[rtl/qat_core.sv]
`default_nettype none

module qat_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 advance,
    input  wire logic [7:0]           ch,
    output qat_pkg::qat_result_t      result
);
    import qat_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  escape_value_reg;
    logic [7:0]  escape_value_next;
    qat_result_t res;
    logic [7:0]  oct_diff;
    logic [7:0]  hex_diff;
    logic        hex_ok;

    always_comb begin
        oct_diff = ch - CH_ZERO;
        hex_ok   = 1'b1;
        if ((ch >= CH_ZERO) && (ch <= CH_NINE)) begin
            hex_diff = ch - CH_ZERO;
        end else if ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) begin
            hex_diff = ch - CH_UP_A + 8'd10;
        end else if ((ch >= CH_LO_A) && (ch <= CH_LO_Z)) begin
            hex_diff = ch - CH_LO_A + 8'd10;
        end else begin
            hex_diff = 8'd0;
            hex_ok   = 1'b0;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        escape_value_next = escape_value_reg;
        res               = '0;
        if (ch == CH_NUL) begin
            if (phase_reg != PH_IDLE) begin
                phase_next  = PH_IDLE;
                res.valid   = 1'b1;
                res.arg_end = 1'b1;
            end
        end else begin
            unique case (phase_reg)
                PH_IDLE: begin
                    if (!is_ws(ch)) begin
                        if (ch == CH_DQUOTE) begin
                            phase_next = PH_QUOTE;
                        end else begin
                            phase_next = PH_BARE;
                            res.valid  = 1'b1;
                            res.data   = ch;
                        end
                    end
                end
                PH_BARE: begin
                    if (is_ws(ch)) begin
                        phase_next  = PH_IDLE;
                        res.valid   = 1'b1;
                        res.arg_end = 1'b1;
                    end else if (ch == CH_DQUOTE) begin
                        phase_next = PH_QUOTE;
                    end else begin
                        res.valid = 1'b1;
                        res.data  = ch;
                    end
                end
                PH_QUOTE: begin
                    if (ch == CH_DQUOTE) begin
                        phase_next = PH_BARE;
                    end else if (ch == CH_BSLASH) begin
                        phase_next = PH_BSL;
                    end else begin
                        res.valid = 1'b1;
                        res.data  = ch;
                    end
                end
                PH_BSL: begin
                    if ((ch >= CH_ZERO) && (ch <= CH_THREE)) begin
                        phase_next        = PH_OCT1;
                        escape_value_next = oct_diff;
                    end else if (ch == CH_X) begin
                        phase_next        = PH_HEX1;
                        escape_value_next = 8'd0;
                    end else begin
                        phase_next = PH_QUOTE;
                        res.valid  = 1'b1;
                        if (ch == CH_N) begin
                            res.data = CH_LF;
                        end else if (ch == CH_R) begin
                            res.data = CH_CR;
                        end else if (ch == CH_T) begin
                            res.data = CH_TAB;
                        end else begin
                            res.data = ch;
                        end
                    end
                end
                PH_OCT1, PH_OCT2: begin
                    if ((ch >= CH_ZERO) && (ch <= CH_SEVEN)) begin
                        escape_value_next = {escape_value_reg[4:0], oct_diff[2:0]};
                    end
                    if (phase_reg == PH_OCT2) begin
                        phase_next = PH_QUOTE;
                        res.valid  = 1'b1;
                        res.data   = escape_value_next;
                    end else begin
                        phase_next = PH_OCT2;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (hex_ok) begin
                        escape_value_next = {escape_value_reg[3:0], 4'd0}
                                            | {2'd0, hex_diff[5:0]};
                    end
                    if (phase_reg == PH_HEX2) begin
                        phase_next = PH_QUOTE;
                        res.valid  = 1'b1;
                        res.data   = escape_value_next;
                    end else begin
                        phase_next = PH_HEX2;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            escape_value_reg <= 8'd0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            escape_value_reg <= escape_value_next;
        end
    end

    assign result = advance ? res : '0;

endmodule

`default_nettype wire

[rtl/qat_out_buf.sv]
`default_nettype none

module qat_out_buf (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire qat_pkg::qat_result_t push,
    output logic                      full,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [7:0]                m_out_byte,
    output logic                      m_arg_end
);
    import qat_pkg::*;

    logic       main_valid_reg;
    logic [7:0] main_data_reg;
    logic       main_end_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;
    logic       skid_end_reg;
    logic       pop;

    assign pop = main_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (push.valid) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
                main_data_reg  <= push.data;
                main_end_reg   <= push.arg_end;
            end else begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= push.data;
                skid_end_reg   <= push.arg_end;
            end
        end else if (pop) begin
            if (skid_valid_reg) begin
                main_data_reg  <= skid_data_reg;
                main_end_reg   <= skid_end_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    assign full       = skid_valid_reg;
    assign m_valid    = main_valid_reg;
    assign m_out_byte = main_data_reg;
    assign m_arg_end  = main_end_reg;

endmodule

`default_nettype wire

[rtl/quoted_argument_tokenizer.sv]
// Quoted argument tokenizer.
// The input channel (s_valid, s_ready, s_ch) takes one text byte per request.
// A zero byte ends the text. The result channel (m_valid, m_ready,
// m_out_byte, m_arg_end) gives the bytes of each argument followed by one
// end marker with m_arg_end set and m_out_byte zero. A byte gives at most one
// result; quotes, escape prefixes and whitespace between arguments give none.
// A request is captured in an input register, decoded by the tokenizer state
// machine once the output buffer has room, and its result is registered in the
// output buffer, from which it is shown on the result channel.
// Throughput is one byte per cycle while the receiver keeps m_ready high.
// When the receiver stalls, a two-entry output buffer absorbs results;
// s_ready drops once the buffer's second entry is occupied and a byte waits
// in the input register, and no result is lost or repeated.
// Synchronous active-low reset empties all registers and puts the tokenizer
// between arguments with a zero escape value.
`default_nettype none

module quoted_argument_tokenizer (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_out_byte,
    output logic            m_arg_end
);
    import qat_pkg::*;

    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        buf_full;
    logic        advance;
    qat_result_t result;

    assign advance = in_valid_reg && !buf_full;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_ch_reg <= s_ch;
        end
    end

    qat_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .ch      (in_ch_reg),
        .result  (result)
    );

    qat_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (result),
        .full       (buf_full),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_arg_end  (m_arg_end)
    );

endmodule

`default_nettype wire

[test/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import qat_pkg::*;

    localparam int RANDOM_TEXT_LEN = 700;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 20;

    typedef struct {
        logic [7:0] ch;
        bit         typed;
        bit         t_has;
        logic [7:0] t_byte;
        bit         t_end;
    } stim_row_t;

    typedef struct {
        logic [7:0] ob;
        bit         ae;
    } arg_item_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_ch;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_byte;
    logic       m_arg_end;

    arg_item_t  arg_expect_q[$];
    logic [7:0] text_q[$];
    stim_row_t  dir_rows[28];
    phase_t     tok_phase;
    logic [7:0] esc_val;
    int         err_count = 0;
    int         cycle_count = 0;
    bit         send_burst;
    bit         recv_burst = 1'b0;

    quoted_argument_tokenizer u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_ch      (s_ch),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_byte(m_out_byte),
        .m_arg_end (m_arg_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic void tokenize_byte(input logic [7:0] c, output bit has,
                                          output logic [7:0] ob, output bit ae);
        logic [7:0] nib;
        bit         ok;
        has = 1'b0;
        ob  = 8'h00;
        ae  = 1'b0;
        nib = 8'h00;
        ok  = 1'b1;
        if (c == CH_NUL) begin
            if (tok_phase != PH_IDLE) begin
                has = 1'b1;
                ae  = 1'b1;
            end
            tok_phase = PH_IDLE;
        end else begin
            case (tok_phase)
                PH_IDLE, PH_BARE: begin
                    if (blank_char(c)) begin
                        if (tok_phase == PH_BARE) begin
                            has = 1'b1;
                            ae  = 1'b1;
                        end
                        tok_phase = PH_IDLE;
                    end else if (c == CH_DQUOTE) begin
                        tok_phase = PH_QUOTE;
                    end else begin
                        tok_phase = PH_BARE;
                        has = 1'b1;
                        ob  = c;
                    end
                end
                PH_QUOTE: begin
                    if (c == CH_DQUOTE) begin
                        tok_phase = PH_BARE;
                    end else if (c == CH_BSLASH) begin
                        tok_phase = PH_BSL;
                    end else begin
                        has = 1'b1;
                        ob  = c;
                    end
                end
                PH_BSL: begin
                    if (c >= CH_ZERO && c <= CH_THREE) begin
                        tok_phase = PH_OCT1;
                        esc_val   = c - CH_ZERO;
                    end else if (c == CH_X) begin
                        tok_phase = PH_HEX1;
                        esc_val   = 8'h00;
                    end else begin
                        tok_phase = PH_QUOTE;
                        has = 1'b1;
                        if (c == CH_N) ob = CH_LF;
                        else if (c == CH_R) ob = CH_CR;
                        else if (c == CH_T) ob = CH_TAB;
                        else ob = c;
                    end
                end
                PH_OCT1, PH_OCT2: begin
                    if (c >= CH_ZERO && c <= CH_SEVEN) esc_val = (esc_val << 3) | (c - CH_ZERO);
                    if (tok_phase == PH_OCT2) begin
                        tok_phase = PH_QUOTE;
                        has = 1'b1;
                        ob  = esc_val;
                    end else begin
                        tok_phase = PH_OCT2;
                    end
                end
                default: begin
                    if (c >= CH_ZERO && c <= CH_NINE) nib = c - CH_ZERO;
                    else if (c >= CH_UP_A && c <= CH_UP_Z) nib = c - CH_UP_A + 8'd10;
                    else if (c >= CH_LO_A && c <= CH_LO_Z) nib = c - CH_LO_A + 8'd10;
                    else ok = 1'b0;
                    if (ok) esc_val = (esc_val << 4) | nib;
                    if (tok_phase == PH_HEX2) begin
                        tok_phase = PH_QUOTE;
                        has = 1'b1;
                        ob  = esc_val;
                    end else begin
                        tok_phase = PH_HEX2;
                    end
                end
            endcase
        end
    endfunction

    function automatic logic [7:0] plain_char(input bit in_quote);
        logic [7:0] c;
        c = 8'h00;
        while (c == CH_NUL || blank_char(c) || c == CH_DQUOTE || (in_quote && c == CH_BSLASH))
            c = 8'($urandom_range(1, 255));
        return c;
    endfunction

    function automatic logic [7:0] blank_pick();
        logic [7:0] c;
        c = 8'($urandom_range(CH_TAB, CH_CR + 1));
        return (c > CH_CR) ? CH_SPACE : c;
    endfunction

    function automatic logic [7:0] hex_pick();
        case ($urandom_range(0, 4))
            0: return 8'($urandom_range(CH_ZERO, CH_NINE));
            1: return 8'($urandom_range(CH_UP_A, CH_UP_Z));
            2: return 8'($urandom_range(CH_LO_A, CH_LO_Z));
            3: return 8'($urandom_range(CH_LO_A, CH_LO_A + 5));
            default: return 8'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [7:0] oct_pick();
        if ($urandom_range(0, 4) != 0) return 8'($urandom_range(CH_ZERO, CH_SEVEN));
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic push_escape();
        text_q.push_back(CH_BSLASH);
        case ($urandom_range(0, 7))
            0: text_q.push_back(CH_N);
            1: text_q.push_back(CH_R);
            2: text_q.push_back(CH_T);
            3: text_q.push_back(($urandom_range(0, 1) != 0) ? CH_BSLASH : CH_DQUOTE);
            4: text_q.push_back(plain_char(1'b0));
            5, 6: begin
                text_q.push_back(8'($urandom_range(CH_ZERO, CH_THREE)));
                text_q.push_back(oct_pick());
                text_q.push_back(oct_pick());
            end
            default: begin
                text_q.push_back(CH_X);
                text_q.push_back(hex_pick());
                text_q.push_back(hex_pick());
            end
        endcase
    endtask

    task automatic build_random_text();
        int nargs;
        int npieces;
        int nlen;
        while (text_q.size() < RANDOM_TEXT_LEN) begin
            if ($urandom_range(0, 9) == 0) begin
                nlen = $urandom_range(1, 8);
                repeat (nlen) text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(0, 2)) text_q.push_back(blank_pick());
                nargs = $urandom_range(1, 4);
                for (int a = 0; a < nargs; a++) begin
                    npieces = $urandom_range(1, 3);
                    for (int p = 0; p < npieces; p++) begin
                        if ($urandom_range(0, 1) != 0) begin
                            repeat ($urandom_range(1, 4)) text_q.push_back(plain_char(1'b0));
                        end else begin
                            text_q.push_back(CH_DQUOTE);
                            repeat ($urandom_range(0, 5)) begin
                                if ($urandom_range(0, 1) != 0) push_escape();
                                else text_q.push_back(plain_char(1'b1));
                            end
                            if ($urandom_range(0, 9) != 0) text_q.push_back(CH_DQUOTE);
                        end
                    end
                    if (a != nargs - 1 || $urandom_range(0, 1) != 0)
                        repeat ($urandom_range(1, 2)) text_q.push_back(blank_pick());
                end
                if ($urandom_range(0, 19) != 0) text_q.push_back(CH_NUL);
            end
        end
        text_q.push_back(CH_NUL);
    endtask

    task automatic send_char(input logic [7:0] c);
        int gap;
        if ($urandom_range(0, 39) == 0) send_burst = ~send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_ch    <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic queue_prediction(input logic [7:0] c, input stim_row_t row);
        bit         has;
        logic [7:0] ob;
        bit         ae;
        tokenize_byte(c, has, ob, ae);
        if (row.typed) begin
            has = row.t_has;
            ob  = row.t_byte;
            ae  = row.t_end;
        end
        if (has) arg_expect_q.push_back('{ob, ae});
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        arg_item_t want;
        int        gap;
        m_ready <= 1'b0;
        @(posedge aresetn);
        @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) recv_burst = ~recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 10);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (arg_expect_q.size() == 0) begin
                $display("%0t: result with no request pending: out_byte %h arg_end %b",
                         $time, m_out_byte, m_arg_end);
                err_count++;
            end else begin
                want = arg_expect_q.pop_front();
                if (m_out_byte !== want.ob) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.ob, m_out_byte);
                    err_count++;
                end
                if (m_arg_end !== want.ae) begin
                    $display("%0t: arg_end expected %b actual %b", $time, want.ae, m_arg_end);
                    err_count++;
                end
            end
        end
    end

    initial begin
        stim_row_t no_row;
        send_burst  = 1'b0;
        tok_phase   = PH_IDLE;
        esc_val     = 8'h00;
        no_row      = '{CH_NUL, 1'b0, 1'b0, 8'h00, 1'b0};
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_ch    <= CH_NUL;
        dir_rows = '{
            '{CH_NUL,    1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_LO_A,   1'b1, 1'b1, CH_LO_A, 1'b0},
            '{8'hff,     1'b1, 1'b1, 8'hff,   1'b0},
            '{CH_TAB,    1'b1, 1'b1, 8'h00,   1'b1},
            '{CH_DQUOTE, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_DQUOTE, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_CR,     1'b1, 1'b1, 8'h00,   1'b1},
            '{CH_DQUOTE, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_N,      1'b1, 1'b1, CH_LF,   1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_THREE,  1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_SEVEN,  1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_SEVEN,  1'b1, 1'b1, 8'hff,   1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_X,      1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_LO_Z,   1'b0, 1'b0, 8'h00,   1'b0},
            '{CH_UP_Z,   1'b0, 1'b0, 8'h00,   1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_ZERO,   1'b1, 1'b0, 8'h00,   1'b0},
            '{8'h23,     1'b0, 1'b0, 8'h00,   1'b0},
            '{CH_ZERO,   1'b0, 1'b0, 8'h00,   1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 8'h00,   1'b0},
            '{8'h71,     1'b1, 1'b1, 8'h71,   1'b0},
            '{CH_BSLASH, 1'b1, 1'b0, 8'h00,   1'b0},
            '{CH_X,      1'b1, 1'b0, 8'h00,   1'b0},
            '{8'h31,     1'b0, 1'b0, 8'h00,   1'b0},
            '{CH_NUL,    1'b1, 1'b1, 8'h00,   1'b1}
        };
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_char(dir_rows[i].ch);
            queue_prediction(dir_rows[i].ch, dir_rows[i]);
        end

        build_random_text();
        while (text_q.size() != 0) begin
            send_char(text_q[0]);
            queue_prediction(text_q[0], no_row);
            void'(text_q.pop_front());
        end
        s_valid <= 1'b0;

        // Every accepted request has been predicted; wait for the block to drain.
        while (arg_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0 && arg_expect_q.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

[quoted_argument_tokenizer.f]
rtl/qat_pkg.sv
rtl/qat_core.sv
rtl/qat_out_buf.sv
rtl/quoted_argument_tokenizer.sv
test/tb_top.sv
